### hdl/uvs_pkg.sv
// Package for the UV sphere vertex generator: widths, item structs, CORDIC
// constants and register codes. No dependencies.
package uvs_pkg;

  localparam int FW   = 9;   // grid field / register width
  localparam int IW   = 17;  // vertex index width
  localparam int DIVW = 41;  // widest dividend: column << 32 plus half divisor
  localparam int XW   = 33;  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int ATAN_N = 24;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

  typedef enum logic [0:0] {
    REG_LON = 1'b0,
    REG_LAT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FW-1:0] col;
    logic [FW-1:0] row;
    logic          quad_valid;
    logic [IW-1:0] a0;
    logic [IW-1:0] a1;
    logic [IW-1:0] a2;
    logic [IW-1:0] b2;
  } grid_item_t;

  typedef struct packed {
    logic       valid;
    grid_item_t item;
  } push_t;

  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

### hdl/uvs_if.sv
// Valid/ready channel interfaces for grid points and vertex results.
// Depends on uvs_pkg for field widths.
interface uvs_in_if import uvs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [FW-1:0] column;
  logic [FW-1:0] row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface uvs_out_if import uvs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [IW-1:0]      tex_u;
  logic [IW-1:0]      tex_v;
  logic               quad_valid;
  logic [IW-1:0]      tri_a0;
  logic [IW-1:0]      tri_a1;
  logic [IW-1:0]      tri_a2;
  logic [IW-1:0]      tri_b0;
  logic [IW-1:0]      tri_b1;
  logic [IW-1:0]      tri_b2;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, quad_valid,
                  tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, quad_valid,
                  tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, output ready);
endinterface

### hdl/uvs_front.sv
// Front end: takes a grid point, clamps it and works out quad indices.
// Depends on uvs_pkg and uvs_in_if.
module uvs_front import uvs_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  uvs_in_if.sink        in_ch,
  input  logic [FW-1:0] n_eff,
  input  logic [FW-1:0] m_eff,
  output push_t         push,
  input  logic          push_ready
);
  logic       fv_r, fv_nxt;
  grid_item_t fi_r, fi_nxt;
  logic       take;

  logic [FW-1:0] col, row;
  logic [FW:0]   w;
  logic [19:0]   here, below;

  assign in_ch.ready = !fv_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    col   = (in_ch.column > n_eff) ? n_eff : in_ch.column;
    row   = (in_ch.row > m_eff) ? m_eff : in_ch.row;
    w     = {1'b0, n_eff} + (FW+1)'(1);
    here  = 20'(row * w) + 20'(col);
    below = here + 20'(w);
    fi_nxt.col        = col;
    fi_nxt.row        = row;
    fi_nxt.quad_valid = (col < n_eff) && (row < m_eff);
    fi_nxt.a0 = fi_nxt.quad_valid ? below[IW-1:0] : '0;
    fi_nxt.a1 = fi_nxt.quad_valid ? here[IW-1:0] : '0;
    fi_nxt.a2 = fi_nxt.quad_valid ? IW'(here + 20'd1) : '0;
    fi_nxt.b2 = fi_nxt.quad_valid ? IW'(below + 20'd1) : '0;
    fv_nxt = take ? 1'b1 : (push_ready ? 1'b0 : fv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    if (take) begin
      fi_r <= fi_nxt;
    end
  end

  assign push.valid = fv_r;
  assign push.item  = fi_r;
endmodule

### hdl/uvs_fifo.sv
// Short queue between front and back end, four items deep.
// Depends on uvs_pkg.
module uvs_fifo import uvs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       push_ready,
  output logic       pop_valid,
  output grid_item_t pop_item,
  input  logic       pop
);
  grid_item_t  mem_r [4];
  logic [1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 3'd4);
  assign pop_valid  = (cnt_r != 3'd0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + (do_push ? 3'd1 : 3'd0) - (do_pop ? 3'd1 : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push.item;
    end
  end
endmodule

### hdl/uvs_div.sv
// Pipelined restoring divider by a 9-bit divisor, four quotient bits a stage.
// Depends on uvs_pkg.
module uvs_div import uvs_pkg::*; #(
  parameter int NB = 41
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] dividend,
  input  logic [FW-1:0] divisor,
  output logic [NB-1:0] quotient
);
  localparam int STAGES = (NB + 3) / 4;
  localparam int PW     = STAGES * 4;

  logic [PW-1:0] w_r [STAGES];
  logic [FW:0]   r_r [STAGES];
  logic [PW-1:0] w_in [STAGES];
  logic [FW:0]   r_in [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PW-1:0] w;
    logic [FW:0]   r;
    if (s == 0) begin : g_first
      assign w_in[s] = PW'(dividend);
      assign r_in[s] = '0;
    end else begin : g_rest
      assign w_in[s] = w_r[s-1];
      assign r_in[s] = r_r[s-1];
    end
    always_comb begin
      w = w_in[s];
      r = r_in[s];
      for (int k = 0; k < 4; k++) begin
        r = {r[FW-1:0], w[PW-1]};
        w = {w[PW-2:0], 1'b0};
        if (r >= {1'b0, divisor}) begin
          r    = r - {1'b0, divisor};
          w[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        w_r[s] <= w;
        r_r[s] <= r;
      end
    end
  end

  assign quotient = w_r[STAGES-1][NB-1:0];
endmodule

### hdl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC: cos and sin of a phase in turns, Q2.30.
// Depends on uvs_pkg for the arctangent table and gain.
module uvs_cordic import uvs_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          phase,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);
  logic signed [XW-1:0] x_r [ITER];
  logic signed [XW-1:0] y_r [ITER];
  logic signed [XW-1:0] z_r [ITER];
  logic [1:0]           q_r [ITER];
  logic signed [XW-1:0] x_in [ITER];
  logic signed [XW-1:0] y_in [ITER];
  logic signed [XW-1:0] z_in [ITER];
  logic [1:0]           q_in [ITER];
  logic signed [XW-1:0] c_r, s_r, c_nxt, s_nxt;

  for (genvar i = 0; i < ITER; i++) begin : g_it
    logic signed [XW-1:0] at;
    if (i == 0) begin : g_first
      assign x_in[i] = CORDIC_GAIN;
      assign y_in[i] = '0;
      assign z_in[i] = XW'({3'b0, phase[29:0]});
      assign q_in[i] = phase[31:30];
    end else begin : g_rest
      assign x_in[i] = x_r[i-1];
      assign y_in[i] = y_r[i-1];
      assign z_in[i] = z_r[i-1];
      assign q_in[i] = q_r[i-1];
    end
    assign at = XW'(ATAN_TURNS[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_in[i][XW-1]) begin
          x_r[i] <= x_in[i] - (y_in[i] >>> i);
          y_r[i] <= y_in[i] + (x_in[i] >>> i);
          z_r[i] <= z_in[i] - at;
        end else begin
          x_r[i] <= x_in[i] + (y_in[i] >>> i);
          y_r[i] <= y_in[i] - (x_in[i] >>> i);
          z_r[i] <= z_in[i] + at;
        end
        q_r[i] <= q_in[i];
      end
    end
  end

  always_comb begin
    case (q_r[ITER-1])
      2'd0: begin c_nxt = x_r[ITER-1];  s_nxt = y_r[ITER-1];  end
      2'd1: begin c_nxt = -y_r[ITER-1]; s_nxt = x_r[ITER-1];  end
      2'd2: begin c_nxt = -x_r[ITER-1]; s_nxt = -y_r[ITER-1]; end
      default: begin c_nxt = y_r[ITER-1]; s_nxt = -x_r[ITER-1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
  end

  assign cos_o = c_r;
  assign sin_o = s_r;
endmodule

### hdl/uvs_back.sv
// Back end: dividers, two CORDICs, products and Q1.15 rounding, one stalling
// pipeline. Depends on uvs_pkg, uvs_div, uvs_cordic and uvs_out_if.
module uvs_back import uvs_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [FW-1:0] n_eff,
  input  logic [FW-1:0] m_eff,
  input  logic          pop_valid,
  input  grid_item_t    pop_item,
  output logic          pop,
  uvs_out_if.source     out_ch
);
  localparam int DSTG = (DIVW + 3) / 4;
  localparam int TD   = ITER + 3;
  localparam int L    = DSTG + TD;

  logic            en;
  logic            v_r  [L];
  grid_item_t      sb_r [L];
  logic [2*IW-1:0] tx_r [TD];
  logic [DIVW-1:0] pu_q, pv_q, tu_q, tv_q;
  logic [DIVW-1:0] pu_d, pv_d, tu_d, tv_d;
  logic signed [XW-1:0]   cu, su, cv, sv;
  logic signed [2*XW-1:0] px_r, pz_r;
  logic signed [XW-1:0]   cv_r;
  logic signed [15:0]     ox_r, oy_r, oz_r;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      return 16'sd32767;
    end else if (v < -22'sd32768) begin
      return -16'sd32768;
    end else begin
      return v[15:0];
    end
  endfunction

  assign en  = !v_r[L-1] || out_ch.ready;
  assign pop = en && pop_valid;

  always_comb begin
    pu_d = {pop_item.col, 32'b0} + DIVW'(n_eff >> 1);
    pv_d = DIVW'({pop_item.row, 31'b0}) + DIVW'(m_eff >> 1);
    tu_d = DIVW'({pop_item.col, 16'b0}) + DIVW'(n_eff >> 1);
    tv_d = DIVW'({pop_item.row, 16'b0}) + DIVW'(m_eff >> 1);
  end

  uvs_div #(.NB(DIVW)) u_div_pu (.clk, .en, .dividend(pu_d), .divisor(n_eff), .quotient(pu_q));
  uvs_div #(.NB(DIVW)) u_div_pv (.clk, .en, .dividend(pv_d), .divisor(m_eff), .quotient(pv_q));
  uvs_div #(.NB(DIVW)) u_div_tu (.clk, .en, .dividend(tu_d), .divisor(n_eff), .quotient(tu_q));
  uvs_div #(.NB(DIVW)) u_div_tv (.clk, .en, .dividend(tv_d), .divisor(m_eff), .quotient(tv_q));

  uvs_cordic #(.ITER(ITER)) u_cordic_u (
    .clk, .en, .phase(pu_q[31:0]), .cos_o(cu), .sin_o(su)
  );
  uvs_cordic #(.ITER(ITER)) u_cordic_v (
    .clk, .en, .phase(pv_q[31:0]), .cos_o(cv), .sin_o(sv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= pop_valid;
      for (int i = 1; i < L; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= pop_item;
      for (int i = 1; i < L; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
      tx_r[0] <= {tu_q[IW-1:0], tv_q[IW-1:0]};
      for (int i = 1; i < TD; i++) begin
        tx_r[i] <= tx_r[i-1];
      end
      px_r <= cu * sv;
      pz_r <= su * sv;
      cv_r <= cv;
      ox_r <= sat16(22'((px_r + (66'sd1 <<< 44)) >>> 45));
      oz_r <= sat16(22'((pz_r + (66'sd1 <<< 44)) >>> 45));
      oy_r <= sat16(22'((cv_r + XW'(32'sd16384)) >>> 15));
    end
  end

  assign out_ch.valid      = v_r[L-1];
  assign out_ch.pos_x      = ox_r;
  assign out_ch.pos_y      = oy_r;
  assign out_ch.pos_z      = oz_r;
  assign out_ch.tex_u      = tx_r[TD-1][2*IW-1:IW];
  assign out_ch.tex_v      = tx_r[TD-1][IW-1:0];
  assign out_ch.quad_valid = sb_r[L-1].quad_valid;
  assign out_ch.tri_a0     = sb_r[L-1].a0;
  assign out_ch.tri_a1     = sb_r[L-1].a1;
  assign out_ch.tri_a2     = sb_r[L-1].a2;
  assign out_ch.tri_b0     = sb_r[L-1].a0;
  assign out_ch.tri_b1     = sb_r[L-1].a2;
  assign out_ch.tri_b2     = sb_r[L-1].b2;
endmodule

### hdl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator top level: configuration registers, front end,
// queue and back end. Depends on uvs_pkg, uvs_if and all uvs_* modules.
//
// Grid points (column, row) enter on in_ch; one vertex result per point
// leaves on out_ch, in order. Both are valid/ready channels. The segment
// counts are written through cfg_we/cfg_index/cfg_data, index 0 longitude,
// 1 latitude; the user must write them only while the block is idle, as the
// block does not enforce this. A count of 0 acts as 1. Throughput: one item
// per cycle when out_ch is ready. Path: the front-end register and queue,
// then in the back end the 11-stage divider pipeline, one CORDIC stage per
// iteration, the CORDIC output register and the product and rounding
// registers.
// A stall on out_ch freezes the back end; the 4-item queue and the front
// register then fill, and in_ch.ready falls only when both are full.
// Synchronous reset empties the pipeline and queue and sets both segment
// counts to 16.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS    = 256,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  uvs_in_if.sink        in_ch,
  uvs_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [FW-1:0] cfg_data
);
  logic [FW-1:0] lon_r, lat_r;
  logic [FW-1:0] n_eff, m_eff;
  push_t         push;
  logic          push_ready, pop_valid, pop;
  grid_item_t    pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= FW'(16);
      lat_r <= FW'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LON: lon_r <= cfg_data;
        REG_LAT: lat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = lon_r;
    if (lon_r == '0) begin
      n_eff = FW'(1);
    end else if ({2'b0, lon_r} > 11'(MAX_SEGMENTS)) begin
      n_eff = FW'(MAX_SEGMENTS);
    end
    m_eff = lat_r;
    if (lat_r == '0) begin
      m_eff = FW'(1);
    end else if ({2'b0, lat_r} > 11'(MAX_SEGMENTS)) begin
      m_eff = FW'(MAX_SEGMENTS);
    end
  end

  uvs_front u_front (
    .clk, .rst_n, .in_ch, .n_eff, .m_eff, .push, .push_ready
  );

  uvs_fifo u_fifo (
    .clk, .rst_n, .push, .push_ready, .pop_valid, .pop_item, .pop
  );

  uvs_back #(.ITER(TRIG_ITERATIONS)) u_back (
    .clk, .rst_n, .n_eff, .m_eff, .pop_valid, .pop_item, .pop, .out_ch
  );
endmodule
